>>> rtl/core/keyword_and_line_length_scanner_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef KEYWORD_AND_LINE_LENGTH_SCANNER_MACROS_SVH
`define KEYWORD_AND_LINE_LENGTH_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KWLS_ASSERT_SAME(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KWLS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

>>> rtl/core/kwls_pkg.sv
// Shared types, constants and keyword table of the keyword and line length scanner.
`timescale 1ns / 1ps
package kwls_pkg;

  // Sizes of the keyword table and of the counters.
  localparam int KEYWORD_COUNT = 12;
  localparam int KEYWORD_SLOT  = 9;
  localparam int PROG_W        = 4;
  localparam int HIT_W         = 4;
  localparam int RUN_W         = 11;
  localparam int LIMIT_W       = 10;
  localparam int THR_W         = 4;
  localparam int CFG_W         = 10;
  localparam int CFG_IDX_W     = 1;
  localparam int HITS_MAX      = 15;
  localparam int HIT_SUM_W     = $clog2(HITS_MAX + KEYWORD_COUNT + 1);

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST    = LIMIT_W'(76);
  localparam logic [THR_W-1:0]   HIT_THRESHOLD_RST = THR_W'(2);

  // Separator characters.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LIMIT    = 1'b0,
    CFG_HIT_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef logic [7:0]                  kw_char_t;
  typedef logic [8*KEYWORD_SLOT-1:0]   kw_text_t;
  typedef logic [PROG_W-1:0]           prog_t;

  // One processing step handed from the input register to the state blocks.
  typedef struct packed {
    logic     go;
    logic     last;
    kw_char_t text_byte;
  } kwls_step_t;

  // Keywords, right-justified: the first character is the most significant byte.
  localparam kw_text_t KW_TEXT [KEYWORD_COUNT] = '{
    kw_text_t'("gratuito"), kw_text_t'("atencao"),  kw_text_t'("urgente"),
    kw_text_t'("imediato"), kw_text_t'("zoombie"),  kw_text_t'("oferta"),
    kw_text_t'("dinheiro"), kw_text_t'("renda"),    kw_text_t'("fundo"),
    kw_text_t'("limitado"), kw_text_t'("ajuda"),    kw_text_t'("SOS")
  };

  localparam prog_t KW_LEN [KEYWORD_COUNT] = '{
    4'd8, 4'd7, 4'd7, 4'd8, 4'd7, 4'd6, 4'd8, 4'd5, 4'd5, 4'd8, 4'd5, 4'd3
  };

  // Character at position p of keyword k; zero past the end of the word.
  function automatic kw_char_t kw_char(input int k, input prog_t p);
    kw_text_t row;
    int       sh;
    row     = KW_TEXT[k];
    sh      = 0;
    kw_char = '0;
    if (p < KW_LEN[k]) begin
      sh      = 8 * (int'(KW_LEN[k]) - 1 - int'(p));
      row     = row >> sh;
      kw_char = row[7:0];
    end
  endfunction

endpackage

>>> rtl/core/kwls_match.sv
// Keyword prefix matchers and the saturating hit counter.
`timescale 1ns / 1ps
module kwls_match (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kwls_pkg::kwls_step_t        step,
  output logic [kwls_pkg::HIT_W-1:0]  hit_count_nxt,
  output logic [kwls_pkg::HIT_W-1:0]  hit_count_q
);

  logic                              at_word_start_r;
  logic                              at_word_start_nxt;
  kwls_pkg::prog_t                   prog_r   [kwls_pkg::KEYWORD_COUNT];
  kwls_pkg::prog_t                   prog_nxt [kwls_pkg::KEYWORD_COUNT];
  logic [kwls_pkg::KEYWORD_COUNT-1:0] hit_vec;
  logic [kwls_pkg::HIT_W-1:0]        hit_count_r;
  logic [kwls_pkg::HIT_SUM_W-1:0]    hit_sum;
  logic                              is_sep;

  // A separator makes the next byte a word start.
  assign is_sep = (step.text_byte == kwls_pkg::CH_SPACE) ||
                  (step.text_byte == kwls_pkg::CH_TAB)   ||
                  (step.text_byte == kwls_pkg::CH_LF)    ||
                  (step.text_byte == kwls_pkg::CH_CR);
  assign at_word_start_nxt = is_sep;

  // One matcher lane per keyword.
  for (genvar k = 0; k < kwls_pkg::KEYWORD_COUNT; k++) begin : g_lane
    kwls_pkg::prog_t p_eff;
    logic            active;
    logic            char_ok;
    logic            done;

    always_comb begin
      p_eff   = at_word_start_r ? '0 : prog_r[k];
      active  = (at_word_start_r || (prog_r[k] != '0)) && (kwls_pkg::KW_LEN[k] != '0);
      char_ok = active && (p_eff < kwls_pkg::KW_LEN[k]) &&
                (kwls_pkg::kw_char(k, p_eff) == step.text_byte);
      done    = char_ok && ((p_eff + kwls_pkg::PROG_W'(1)) == kwls_pkg::KW_LEN[k]);
      hit_vec[k]  = done;
      prog_nxt[k] = (char_ok && !done) ? (p_eff + kwls_pkg::PROG_W'(1)) : '0;
    end
  end

  // Add this byte's completions with saturation.
  always_comb begin
    hit_sum = kwls_pkg::HIT_SUM_W'($countones(hit_vec)) +
              kwls_pkg::HIT_SUM_W'(hit_count_r);
    if (hit_sum > kwls_pkg::HIT_SUM_W'(kwls_pkg::HITS_MAX)) begin
      hit_count_nxt = kwls_pkg::HIT_W'(kwls_pkg::HITS_MAX);
    end else begin
      hit_count_nxt = hit_sum[kwls_pkg::HIT_W-1:0];
    end
  end

  // State update; the last byte of a message clears everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_word_start_r <= 1'b1;
      hit_count_r     <= '0;
      for (int i = 0; i < kwls_pkg::KEYWORD_COUNT; i++) begin
        prog_r[i] <= '0;
      end
    end else if (step.go) begin
      if (step.last) begin
        at_word_start_r <= 1'b1;
        hit_count_r     <= '0;
        for (int i = 0; i < kwls_pkg::KEYWORD_COUNT; i++) begin
          prog_r[i] <= '0;
        end
      end else begin
        at_word_start_r <= at_word_start_nxt;
        hit_count_r     <= hit_count_nxt;
        for (int i = 0; i < kwls_pkg::KEYWORD_COUNT; i++) begin
          prog_r[i] <= prog_nxt[i];
        end
      end
    end
  end

  assign hit_count_q = hit_count_r;

endmodule

>>> rtl/core/kwls_line.sv
// Line run length counter and long line flag.
`timescale 1ns / 1ps
module kwls_line (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kwls_pkg::kwls_step_t          step,
  input  logic [kwls_pkg::LIMIT_W-1:0]  line_limit,
  output logic                          long_flag_nxt,
  output logic                          long_flag_q
);

  logic [kwls_pkg::RUN_W-1:0] run_r;
  logic [kwls_pkg::RUN_W-1:0] run_nxt;
  logic                       long_flag_r;
  logic                       is_eol;

  // A CR or LF ends the line; other bytes extend the run up to its maximum.
  always_comb begin
    is_eol        = (step.text_byte == kwls_pkg::CH_LF) ||
                    (step.text_byte == kwls_pkg::CH_CR);
    run_nxt       = '0;
    long_flag_nxt = long_flag_r;
    if (!is_eol) begin
      run_nxt = (run_r == '1) ? run_r : (run_r + kwls_pkg::RUN_W'(1));
      if (run_nxt > kwls_pkg::RUN_W'(line_limit)) begin
        long_flag_nxt = 1'b1;
      end
    end
  end

  // State update; the last byte of a message clears the run and the flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      long_flag_r <= 1'b0;
    end else if (step.go) begin
      if (step.last) begin
        run_r       <= '0;
        long_flag_r <= 1'b0;
      end else begin
        run_r       <= run_nxt;
        long_flag_r <= long_flag_nxt;
      end
    end
  end

  assign long_flag_q = long_flag_r;

endmodule

>>> rtl/core/keyword_and_line_length_scanner.sv
// Top level of the keyword and line length scanner.
//
// Usage: message bytes enter on the in_ channel, one item per byte, with
// in_end_of_message high on the final byte. Each item is taken at a rising
// edge with in_valid high and in_stall low. Only the final byte of a message
// produces a result item on the out_ channel (is_spam, long_line_seen,
// keyword_hits); other bytes produce none.
// A byte is held in the input register while the matchers and the line
// counter work on it, and its verdict enters the output register at the edge
// on which the byte leaves the input register. Throughput is one byte per
// cycle while in_stall is low, set by the single pass through the twelve
// parallel keyword comparators and the hit adder.
// A held result does not block the input: non-final bytes keep flowing while
// out_stall is high, and in_stall rises only when a final byte is waiting for
// a stalled output register.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
// index 0 is line_limit, index 1 is hit_threshold.
// Reset (rst_n low, synchronous) clears all scanning state, empties both
// registers and restores line_limit to 76 and hit_threshold to 2. The last
// byte of each message also clears the scanning state.
`timescale 1ns / 1ps
`include "keyword_and_line_length_scanner_macros.svh"
module keyword_and_line_length_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_end_of_message,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_spam,
  output logic                            out_long_line_seen,
  output logic [kwls_pkg::HIT_W-1:0]      out_keyword_hits,
  input  logic                            cfg_we,
  input  logic [kwls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kwls_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [kwls_pkg::LIMIT_W-1:0] line_limit_r;
  logic [kwls_pkg::THR_W-1:0]   hit_threshold_r;

  logic                         stage_vld_r;
  logic [7:0]                   stage_byte_r;
  logic                         stage_eom_r;
  logic                         stage_go;
  logic                         in_take;
  logic                         out_free;
  logic                         out_load;

  kwls_pkg::kwls_step_t         step;
  logic [kwls_pkg::HIT_W-1:0]   hit_count_nxt;
  logic [kwls_pkg::HIT_W-1:0]   hit_count_q;
  logic                         long_flag_nxt;
  logic                         long_flag_q;

  logic                         out_vld_r;
  logic                         out_spam_r;
  logic                         out_long_r;
  logic [kwls_pkg::HIT_W-1:0]   out_hits_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r    <= kwls_pkg::LINE_LIMIT_RST;
      hit_threshold_r <= kwls_pkg::HIT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (kwls_pkg::cfg_idx_t'(cfg_index))
        kwls_pkg::CFG_LINE_LIMIT:    line_limit_r    <= cfg_wdata[kwls_pkg::LIMIT_W-1:0];
        kwls_pkg::CFG_HIT_THRESHOLD: hit_threshold_r <= cfg_wdata[kwls_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a final byte needs room in the output register to advance.
  assign out_free = !out_vld_r || !out_stall;
  assign stage_go = stage_vld_r && (!stage_eom_r || out_free);
  assign in_stall = stage_vld_r && !stage_go;
  assign in_take  = in_valid && !in_stall;
  assign out_load = stage_go && stage_eom_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_take) begin
      stage_vld_r <= 1'b1;
    end else if (stage_go) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_text_byte;
      stage_eom_r  <= in_end_of_message;
    end
  end

  assign step.go        = stage_go;
  assign step.last      = stage_eom_r;
  assign step.text_byte = stage_byte_r;

  kwls_match u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .hit_count_nxt (hit_count_nxt),
    .hit_count_q   (hit_count_q)
  );

  kwls_line u_line (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .line_limit    (line_limit_r),
    .long_flag_nxt (long_flag_nxt),
    .long_flag_q   (long_flag_q)
  );

  // Output register holding the verdict of the last finished message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_spam_r <= long_flag_nxt || (hit_count_nxt >= hit_threshold_r);
      out_long_r <= long_flag_nxt;
      out_hits_r <= hit_count_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_is_spam        = out_spam_r;
  assign out_long_line_seen = out_long_r;
  assign out_keyword_hits   = out_hits_r;

  // A held byte in the input register only waits on a stalled, full output.
  `KWLS_ASSERT_SAME(a_stall_cause, clk, rst_n, stage_vld_r && !stage_go,
    stage_eom_r && out_vld_r && out_stall)
  // The end of a message leaves the hit counter and long line flag cleared.
  `KWLS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, out_load,
    (hit_count_q == '0) && !long_flag_q)
  // A freshly loaded result reports the flag in its verdict.
  `KWLS_ASSERT_NEXT(a_spam_covers_long, clk, rst_n, out_load && long_flag_nxt,
    out_vld_r && out_is_spam && out_long_line_seen)

endmodule
